### src/assert_macros.svh
// Assertion macros shared by the RTL of the density evaluator.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication that must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rde_pkg.sv
// Package of the density evaluator: widths, format constants, mode codes and the
// constant 2^(-j/2^B) table built at elaboration. Depends on nothing.
package rde_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int EXP_TABLE_BITS = 8;

   localparam int DW  = 32;                 // value and x word width
   localparam int XMW = DW - 1;             // magnitude of a positive x
   localparam int KW  = 32;                 // register k
   localparam int Q   = 30;                 // table and log2(e) fraction bits

   localparam int TBL_LEN = (1 << EXP_TABLE_BITS) + 1;
   localparam int TIW     = $clog2(TBL_LEN);
   localparam int RW      = Q - EXP_TABLE_BITS;      // interpolation remainder
   localparam int DFW     = RW + 1;                  // neighbouring entry difference
   localparam int DMW     = DFW + RW;

   localparam int ZW  = FRAC_BITS + 7;      // z is capped at 64.0
   localparam int TW  = ZW - 1;
   localparam int UW  = ZW;
   localparam int NW  = UW - FRAC_BITS;
   localparam int EW  = FRAC_BITS + 1;      // exp(-t) lies in [0, 1.0]
   localparam int SHIFT_LIM_BITS = $clog2(DW);
   localparam int SHW = $clog2(Q - FRAC_BITS + DW);

   localparam logic [ZW-1:0] Z_CAP = {1'b1, {(ZW-1){1'b0}}};
   localparam logic [ZW-1:0] ONE_Z = ZW'(1) << FRAC_BITS;
   localparam logic [EW-1:0] ONE_E = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [Q:0]    LOG2E_Q30 = 31'd1549082005;
   localparam logic [KW-1:0] K_RESET = KW'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      MODE_DENSITY = 2'd0,
      MODE_DERIV   = 2'd1,
      MODE_DIST    = 2'd2
   } mode_type;

   typedef logic [Q:0] tbl_type [TBL_LEN];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      logic [63:0] rv;
      int          s;
      res   = '0;
      bit_w = 64'd1 << 62;
      rv    = v;
      for (s = 0; s < 32; s++) begin
         if (rv >= res + bit_w) begin
            rv  = rv - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Roots 2^(-2^i/2^B) come from repeated square roots of one half; each entry
   // is the rounded product of the roots selected by the bits of its index.
   function automatic tbl_type exp_tbl_build();
      tbl_type     t;
      logic [63:0] roots [EXP_TABLE_BITS];
      logic [63:0] a;
      logic [63:0] p;
      int          i;
      int          j;
      a = 64'd1 << (Q - 1);
      for (i = EXP_TABLE_BITS - 1; i >= 0; i--) begin
         a        = isqrt64(a << Q);
         roots[i] = a;
      end
      for (j = 0; j < TBL_LEN; j++) begin
         if (j == (1 << EXP_TABLE_BITS)) begin
            t[j] = (Q+1)'(64'd1 << (Q - 1));
         end else begin
            p = 64'd1 << Q;
            for (i = 0; i < EXP_TABLE_BITS; i++) begin
               if (((j >> i) & 1) != 0) begin
                  p = (p * roots[i] + (64'd1 << (Q - 1))) >> Q;
               end
            end
            t[j] = p[Q:0];
         end
      end
      return t;
   endfunction

   localparam tbl_type EXP_TBL = exp_tbl_build();

endpackage

### src/rde_exp_unit.sv
// Four-stage pipelined exp(-z/2) for the density evaluator: log2(e) scaling,
// table lookup, interpolation product and final shift. Depends on rde_pkg.
module rde_exp_unit
   import rde_pkg::*;
(
   input  logic              clock,
   input  logic [3:0]        stage_en,
   input  logic [ZW-1:0]     z,
   output logic [EW-1:0]     e_val
);

   logic [UW-1:0]        u_ff, u_in;
   logic [Q:0]           tj_ff, tj_in, tj2_ff;
   logic [DFW-1:0]       diff_ff, diff_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic                 under_ff, under_in, under2_ff;
   logic [SHW-1:0]       sh_ff, sh_in, sh2_ff;
   logic [DMW-1:0]       dm_ff, dm_in;
   logic [EW-1:0]        e_ff, e_in;

   logic [TW+Q:0]        u_full;
   logic [FRAC_BITS-1:0] g;
   logic [Q-1:0]         g30;
   logic [EXP_TABLE_BITS-1:0] j;
   logic [NW-1:0]        n;
   logic [Q:0]           tj1;
   logic [Q:0]           e30;

   // Exponent in base two: u = t*log2(e), with t = z/2.
   always_comb begin
      u_full = (TW+Q+1)'(z[ZW-1:1]) * (TW+Q+1)'(LOG2E_Q30);
      u_in   = u_full[TW+Q:Q];
   end

   // Integer part becomes a shift, the fraction picks and splits a table interval.
   always_comb begin
      n        = u_ff[UW-1:FRAC_BITS];
      g        = u_ff[FRAC_BITS-1:0];
      g30      = {g, {(Q-FRAC_BITS){1'b0}}};
      j        = g30[Q-1:RW];
      rem_in   = g30[RW-1:0];
      under_in = |n[NW-1:SHIFT_LIM_BITS];
      sh_in    = SHW'(Q - FRAC_BITS) + SHW'(n[SHIFT_LIM_BITS-1:0]);
      tj_in    = EXP_TBL[{1'b0, j}];
      tj1      = EXP_TBL[TIW'(j) + TIW'(1)];
      diff_in  = DFW'(tj_in - tj1);
   end

   assign dm_in = DMW'(diff_ff) * DMW'(rem_ff);

   always_comb begin
      e30  = tj2_ff - (Q+1)'(dm_ff >> RW);
      e_in = under2_ff ? '0 : EW'(e30 >> sh2_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u_ff <= u_in;
      end
      if (stage_en[1]) begin
         tj_ff    <= tj_in;
         diff_ff  <= diff_in;
         rem_ff   <= rem_in;
         under_ff <= under_in;
         sh_ff    <= sh_in;
      end
      if (stage_en[2]) begin
         dm_ff     <= dm_in;
         tj2_ff    <= tj_ff;
         under2_ff <= under_ff;
         sh2_ff    <= sh_ff;
      end
      if (stage_en[3]) begin
         e_ff <= e_in;
      end
   end

   assign e_val = e_ff;

endmodule

### src/rayleigh_density_evaluator_unit.sv
// Top level of the Rayleigh density evaluator: ten-stage pipeline around the
// exp unit. Depends on rde_pkg, rde_exp_unit and assert_macros.svh.
//
// Use: a point x (signed Q16.16) enters on the req_ stream with the mode in
// req_tuser: density, derivative of the density or cumulative distribution.
// One result leaves on the rsp_ stream per point, in order, as a signed Q16.16
// value with a saturation flag in rsp_tuser. Points at or below zero, and the
// unused mode code, give zero.
// The csr_ channel writes k = 1/sigma^2 (unsigned Q16.16); it is always ready
// and should only be written while no point is in flight.
// rsp_tvalid rises once a point has passed all ten register stages, and the block
// takes one point per cycle unless a receiver stall has filled every stage.
// The ten register stages hold the two squaring products, their sum and cap,
// the log2(e) scaling, the table lookup, the interpolation product, the final
// shift, the output products, their sums and the output register.
// Reset empties the pipeline and sets k to 1.0. When the receiver stalls the
// last stage holds its result, empty stages further up still fill, and
// req_tready falls only once every stage holds a point.
`include "assert_macros.svh"

module rayleigh_density_evaluator_unit
   import rde_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [DW-1:0] req_tdata,   // [31:0] x
   input  logic [1:0]    req_tuser,   // [1:0] mode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [DW-1:0] rsp_tdata,   // [31:0] value
   output logic [0:0]    rsp_tuser,   // [0] saturated
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [KW-1:0] csr_wdata
);

   localparam int NSTG = 10;
   localparam int X2W  = 2 * XMW;
   localparam int XKW  = XMW + KW;
   localparam int ZSW  = X2W + KW;
   localparam int ZFW  = ZSW - 2 * FRAC_BITS;
   localparam int DSW  = XKW + EW;
   localparam int DQW  = DSW - 2 * FRAC_BITS;
   localparam int KEW  = KW + EW;
   localparam int KSW  = KEW + ZW;
   localparam int KQW  = KSW - 2 * FRAC_BITS;
   localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};

   logic [KW-1:0]   k_ff;
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   mode_type        mode_ff [0:8];
   logic            pass_ff [0:8];
   logic [XKW-1:0]  xk_ff [0:6];
   logic [ZW-1:0]   d_ff [3:7];
   logic            neg_ff [3:8];

   logic [X2W-1:0]  x2_ff;
   logic [XKW-1:0]  zhi_ff, zlo_ff;
   logic [ZW-1:0]   z_ff, z_in;
   logic [EW-1:0]   e_val;
   logic [DW+EW-1:0] pdlo_ff;
   logic [XMW+EW-1:0] pdhi_ff;
   logic [KEW-1:0]  ke_ff;
   logic [EW-1:0]   dist_ff, dist8_ff;
   logic [DW-1:0]   dval_ff, dval_in;
   logic            dclip_ff, dclip_in;
   logic [DW+ZW-1:0] pklo_ff;
   logic [EW+ZW-1:0] pkhi_ff;
   logic [DW-1:0]   val_ff, val_in;
   logic            sat_ff, sat_in;

   logic [XMW-1:0]  xm;
   mode_type        mode_req;
   logic            pass_req;
   logic [ZSW-1:0]  zsum;
   logic [ZFW-1:0]  zf;
   logic [DSW-1:0]  dsum;
   logic [DQW-1:0]  dq;
   logic [KSW-1:0]  ksum;
   logic [KQW-1:0]  kq, kcap;
   logic [DW-1:0]   kmag, kval;
   logic            kclip;

   // Stage enables: a stage moves when it is empty or its successor moves.
   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         k_ff <= K_RESET;
      end else begin
         if (csr_valid) begin
            k_ff <= csr_wdata;
         end
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      xm       = req_tdata[XMW-1:0];
      mode_req = mode_type'(req_tuser);
      pass_req = !req_tdata[DW-1] && (xm != '0) &&
                 (mode_req == MODE_DENSITY || mode_req == MODE_DERIV ||
                  mode_req == MODE_DIST);
   end

   // z = x*x*k / 2^(2F), capped at 64.0 where exp(-z/2) has long flushed to zero.
   always_comb begin
      zsum = (ZSW'(zhi_ff) << XMW) + ZSW'(zlo_ff);
      zf   = zsum[ZSW-1:2*FRAC_BITS];
      z_in = (zf > ZFW'(Z_CAP)) ? Z_CAP : zf[ZW-1:0];
   end

   rde_exp_unit u_exp (
      .clock    (clock),
      .stage_en (en[6:3]),
      .z        (z_ff),
      .e_val    (e_val)
   );

   always_comb begin
      dsum     = (DSW'(pdhi_ff) << DW) + DSW'(pdlo_ff);
      dq       = dsum[DSW-1:2*FRAC_BITS];
      dclip_in = dq > DQW'(SAT_POS);
      dval_in  = dclip_in ? SAT_POS : dq[DW-1:0];
   end

   // The negative side may reach -2^31, the positive side only 2^31-1.
   always_comb begin
      ksum  = (KSW'(pkhi_ff) << DW) + KSW'(pklo_ff);
      kq    = ksum[KSW-1:2*FRAC_BITS];
      kcap  = neg_ff[8] ? (KQW'(SAT_POS) + KQW'(1)) : KQW'(SAT_POS);
      kclip = kq > kcap;
      kmag  = kclip ? kcap[DW-1:0] : kq[DW-1:0];
      kval  = neg_ff[8] ? (DW'(0) - kmag) : kmag;
   end

   always_comb begin
      val_in = '0;
      sat_in = 1'b0;
      if (pass_ff[8]) begin
         unique case (mode_ff[8])
            MODE_DENSITY: begin
               val_in = dval_ff;
               sat_in = dclip_ff;
            end
            MODE_DERIV: begin
               val_in = kval;
               sat_in = kclip;
            end
            MODE_DIST: begin
               val_in = DW'(dist8_ff);
            end
            default: begin
               val_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mode_ff[0] <= mode_req;
         pass_ff[0] <= pass_req;
         x2_ff      <= X2W'(xm) * X2W'(xm);
         xk_ff[0]   <= XKW'(xm) * XKW'(k_ff);
      end
      for (int i = 1; i < 9; i++) begin
         if (en[i]) begin
            mode_ff[i] <= mode_ff[i-1];
            pass_ff[i] <= pass_ff[i-1];
         end
      end
      for (int i = 1; i < 7; i++) begin
         if (en[i]) begin
            xk_ff[i] <= xk_ff[i-1];
         end
      end
      if (en[1]) begin
         zhi_ff <= XKW'(x2_ff[X2W-1:XMW]) * XKW'(k_ff);
         zlo_ff <= XKW'(x2_ff[XMW-1:0]) * XKW'(k_ff);
      end
      if (en[2]) begin
         z_ff <= z_in;
      end
      if (en[3]) begin
         neg_ff[3] <= z_ff > ONE_Z;
         d_ff[3]   <= (z_ff > ONE_Z) ? (z_ff - ONE_Z) : (ONE_Z - z_ff);
      end
      for (int i = 4; i < 8; i++) begin
         if (en[i]) begin
            neg_ff[i] <= neg_ff[i-1];
            d_ff[i]   <= d_ff[i-1];
         end
      end
      if (en[7]) begin
         pdlo_ff <= (DW+EW)'(xk_ff[6][DW-1:0]) * (DW+EW)'(e_val);
         pdhi_ff <= (XMW+EW)'(xk_ff[6][XKW-1:DW]) * (XMW+EW)'(e_val);
         ke_ff   <= KEW'(k_ff) * KEW'(e_val);
         dist_ff <= ONE_E - e_val;
      end
      if (en[8]) begin
         dval_ff   <= dval_in;
         dclip_ff  <= dclip_in;
         pklo_ff   <= (DW+ZW)'(ke_ff[DW-1:0]) * (DW+ZW)'(d_ff[7]);
         pkhi_ff   <= (EW+ZW)'(ke_ff[KEW-1:DW]) * (EW+ZW)'(d_ff[7]);
         dist8_ff  <= dist_ff;
         neg_ff[8] <= neg_ff[7];
      end
      if (en[9]) begin
         val_ff <= val_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid   = v_ff[NSTG-1];
   assign rsp_tdata    = val_ff;
   assign rsp_tuser[0] = sat_ff;

   `ASSERT_SAME(a_full_stall, clock, reset, (&v_ff) && !rsp_tready, !req_tready,
      "full pipeline accepted a transfer while the output stalled")
   `ASSERT_SAME(a_sat_value, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == SAT_POS || rsp_tdata == (SAT_POS + DW'(1)),
      "saturation flag set on a value that is not a range limit")
   `ASSERT_SAME(a_exp_range, clock, reset, v_ff[6], e_val <= ONE_E,
      "exp unit result above one")
   `ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, v_ff == '0 && !rsp_tvalid,
      "pipeline not empty after reset")

endmodule

### dv/rayleigh_density_evaluator_unit_tb.sv
// Self-checking testbench for the Rayleigh density evaluator: drives points in all modes
// under several settings of k and checks every result against a local predictor.
// Depends on rde_pkg and the top level rayleigh_density_evaluator_unit.
`timescale 1ns / 100ps

module testbench;
   import rde_pkg::*;

   localparam logic [1:0]  MODE_UNUSED  = 2'd3;
   localparam logic [63:0] UNIT_Q       = 64'd1 << FRAC_BITS;
   localparam logic [63:0] Z_LIMIT      = 64'd64 << FRAC_BITS;
   localparam logic [63:0] LOG2E_FIX    = 64'd1549082005;
   localparam logic [63:0] POS_LIMIT    = 64'h7FFF_FFFF;
   localparam logic [63:0] NEG_LIMIT    = 64'h8000_0000;
   localparam int          REM_BITS     = 30 - EXP_TABLE_BITS;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [1:0]    mode;
      logic [DW-1:0] x;
      logic [DW-1:0] value;
      logic          saturated;
   } density_expect_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [DW-1:0] req_tdata;   // [31:0] x
   logic [1:0]    req_tuser;   // [1:0] mode
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [DW-1:0] rsp_tdata;   // [31:0] value
   logic [0:0]    rsp_tuser;   // [0] saturated
   logic          csr_valid;
   logic          csr_ready;
   logic [KW-1:0] csr_wdata;

   logic [63:0]        pow2_frac [TBL_LEN];
   logic [KW-1:0]      k_model;
   logic [63:0]        sigma_point;
   logic               no_gaps = 1'b0;
   density_expect_type pending_results [$];
   int                 mismatch_count  = 0;
   int                 checked_count   = 0;
   int                 saturated_count = 0;
   int                 settings_count  = 0;
   int                 cycle_count     = 0;
   int                 mode_count [4]  = '{0, 0, 0, 0};

   rayleigh_density_evaluator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Floor square root, one result bit at a time from the top.
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] c;
      int          b;
      r = '0;
      for (b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // Entries 2^(-j/2^B) in Q.30, each a rounded product of repeated roots of one half.
   task automatic build_pow2_table();
      logic [63:0] roots [EXP_TABLE_BITS];
      logic [63:0] a;
      logic [63:0] p;
      int          i;
      int          j;
      a = 64'd1 << 29;
      for (i = EXP_TABLE_BITS - 1; i >= 0; i--) begin
         a        = root_floor(a << 30);
         roots[i] = a;
      end
      for (j = 0; j < TBL_LEN; j++) begin
         p = 64'd1 << 30;
         for (i = 0; i < EXP_TABLE_BITS; i++) begin
            if ((j >> i) & 1) p = (p * roots[i] + (64'd1 << 29)) >> 30;
         end
         pow2_frac[j] = (j == (1 << EXP_TABLE_BITS)) ? (64'd1 << 29) : p;
      end
   endtask

   function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] cap, output logic clipped);
      logic [127:0] p;
      p       = ({64'd0, a} * {64'd0, b}) >> (2 * FRAC_BITS);
      clipped = (p > {64'd0, cap});
      return clipped ? cap : p[63:0];
   endfunction

   // exp(-t) as a power of two: integer part shifts, fraction is interpolated.
   function automatic logic [63:0] neg_exp(input logic [63:0] t);
      logic [63:0] u;
      logic [63:0] n;
      logic [63:0] g30;
      logic [63:0] j;
      logic [63:0] rem;
      logic [63:0] e30;
      u   = (t * LOG2E_FIX) >> 30;
      n   = u >> FRAC_BITS;
      g30 = (u & (UNIT_Q - 1)) << (30 - FRAC_BITS);
      j   = g30 >> REM_BITS;
      rem = g30 & ((64'd1 << REM_BITS) - 1);
      if (n >= 32) return '0;
      e30 = pow2_frac[j] - (((pow2_frac[j] - pow2_frac[j + 1]) * rem) >> REM_BITS);
      return e30 >> (30 - FRAC_BITS + n);
   endfunction

   function automatic density_expect_type predict_density(input logic [1:0] m,
                                                          input logic [DW-1:0] x,
                                                          input logic [KW-1:0] k);
      density_expect_type r;
      logic [63:0]        xm;
      logic [63:0]        km;
      logic [63:0]        z;
      logic [63:0]        e;
      logic [63:0]        d;
      logic [63:0]        mag;
      logic [63:0]        val;
      logic               zc;
      logic               clip;
      logic               neg;
      r.mode      = m;
      r.x         = x;
      r.value     = '0;
      r.saturated = 1'b0;
      if (x == 0 || x[DW-1] || m == MODE_UNUSED) return r;
      xm   = {32'd0, x};
      km   = {32'd0, k};
      clip = 1'b0;
      val  = '0;
      z    = scaled_product(xm * xm, km, Z_LIMIT, zc);
      e    = neg_exp(z >> 1);
      case (m)
         MODE_DENSITY: begin
            val = scaled_product(xm * km, e, POS_LIMIT, clip);
         end
         MODE_DERIV: begin
            neg = (z > UNIT_Q);
            d   = neg ? z - UNIT_Q : UNIT_Q - z;
            mag = scaled_product(km * e, d, neg ? NEG_LIMIT : POS_LIMIT, clip);
            val = neg ? -mag : mag;
         end
         default: begin
            val = UNIT_Q - e;
         end
      endcase
      r.value     = val[DW-1:0];
      r.saturated = clip;
      return r;
   endfunction

   function automatic logic [1:0] draw_mode();
      if ($urandom_range(99) < 5) return MODE_UNUSED;
      return 2'($urandom_range(0, 2));
   endfunction

   // Two in five points are scattered around sigma, where all three curves change shape.
   function automatic logic [DW-1:0] draw_x();
      int unsigned pick;
      logic [63:0] scaled;
      pick = $urandom_range(99);
      if (pick < 12) return $urandom;
      if (pick < 20) return -($urandom >> $urandom_range(0, 31));
      if (pick < 60) begin
         scaled = (sigma_point * $urandom_range(0, 8191)) >> 10;
         return scaled[DW-1:0];
      end
      return $urandom >> $urandom_range(1, 31);
   endfunction

   function automatic logic [KW-1:0] draw_k();
      logic [KW-1:0] v;
      v = $urandom >> $urandom_range(0, 31);
      return (v == 0) ? KW'(1) : v;
   endfunction

   task automatic push_point(input logic [1:0] m, input logic [DW-1:0] x);
      while (!no_gaps && $urandom_range(99) < 28) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      req_tuser  <= m;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_density(m, x, k_model));
      mode_count[m]++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_inv_sigma_sq(input logic [KW-1:0] v);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      k_model     = v;
      sigma_point = (v == 0) ? UNIT_Q : root_floor((64'd1 << 48) / v);
      settings_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_register_value();
      push_point(MODE_DENSITY, 32'h0001_0000);
      push_point(MODE_DERIV,   32'h0001_0000);
      push_point(MODE_DIST,    32'h0001_0000);
      push_point(MODE_DENSITY, 32'h0000_0000);
      push_point(MODE_DERIV,   32'hFFFF_0000);
      push_point(MODE_DIST,    32'h8000_0000);
      push_point(MODE_UNUSED,  32'h0001_0000);
      push_point(MODE_DENSITY, 32'h7FFF_FFFF);
      push_point(MODE_DERIV,   32'h7FFF_FFFF);
      push_point(MODE_DIST,    32'h7FFF_FFFF);
      push_point(MODE_DENSITY, 32'h0000_0001);
      push_point(MODE_DERIV,   32'h0000_0001);
   endtask

   task automatic test_register_extremes();
      write_inv_sigma_sq(32'h0000_0000);
      push_point(MODE_DENSITY, 32'h0002_0000);
      push_point(MODE_DERIV,   32'h0002_0000);
      push_point(MODE_DIST,    32'h0002_0000);
      // A tiny point with the largest k drives the derivative past the positive limit.
      write_inv_sigma_sq(32'hFFFF_FFFF);
      push_point(MODE_DERIV,   32'h0000_0001);
      push_point(MODE_DENSITY, 32'h0000_0001);
      push_point(MODE_DIST,    32'h0000_0100);
      push_point(MODE_DERIV,   32'h0000_0100);
      write_inv_sigma_sq(32'h0000_0001);
      push_point(MODE_DENSITY, 32'h7FFF_FFFF);
      push_point(MODE_DERIV,   32'h0100_0000);
      push_point(MODE_DIST,    32'h0100_0000);
   endtask

   task automatic test_random_points();
      int phase;
      int i;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            1:       write_inv_sigma_sq(32'hFFFF_FFFF);
            2:       write_inv_sigma_sq(32'h0000_0001);
            4:       write_inv_sigma_sq(K_RESET);
            default: write_inv_sigma_sq(draw_k());
         endcase
         // One whole phase runs back to back on both sides.
         no_gaps = (phase == 3);
         for (i = 0; i < 55; i++) push_point(draw_mode(), draw_x());
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_sender_pause();
      int burst;
      int i;
      for (burst = 0; burst < 4; burst++) begin
         for (i = 0; i < $urandom_range(3, 8); i++) push_point(draw_mode(), draw_x());
         wait_for_results();
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= no_gaps || ($urandom_range(99) >= 28);
      end
   end

   always @(posedge clock) begin
      density_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count++;
         if (rsp_tuser[0] === 1'b1) saturated_count++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: value %h saturated %b", rsp_tdata, rsp_tuser[0]);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value || rsp_tuser[0] !== want.saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch for mode %0d x %h: expected %h/%b, got %h/%b",
                           want.mode, want.x, want.value, want.saturated,
                           rsp_tdata, rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      k_model     = K_RESET;
      sigma_point = UNIT_Q;
      build_pow2_table();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_register_value();
      test_register_extremes();
      test_random_points();
      test_sender_pause();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d density, %0d derivative, %0d distribution and %0d unused-mode points",
               mode_count[MODE_DENSITY], mode_count[MODE_DERIV], mode_count[MODE_DIST],
               mode_count[MODE_UNUSED]);
      $display("under %0d register writes; %0d results checked, %0d saturated, %0d mismatches.",
               settings_count, checked_count, saturated_count, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
